// ----- src/crb_pkg.sv -----
// Shared types, constants and helpers for the comb/allpass reverberator.
`default_nettype none
package crb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = 18;
  localparam int SUM_W    = 19;

  localparam int COMB_LEN_A_DEF    = 1116;
  localparam int COMB_LEN_B_DEF    = 1188;
  localparam int COMB_LEN_C_DEF    = 1277;
  localparam int COMB_LEN_D_DEF    = 1356;
  localparam int ALLPASS_LEN_A_DEF = 225;
  localparam int ALLPASS_LEN_B_DEF = 341;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 2'd2;

  localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 16'd16384;
  localparam logic [GAIN_W-1:0] ALLPASS_GAIN_RST  = 16'd16384;
  localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST   = 16'd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic clr;
    logic re;
    logic we;
    logic adv;
  } line_ctl_t;

  function automatic sample_t sat16(input sum_t v);
    sample_t r;
    if (v > sum_t'(32767)) begin
      r = 16'sh7fff;
    end else if (v < sum_t'(-32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/comb_allpass_reverb.sv -----
// Top level: four comb lines, two allpass stages and output gain on one multiplier.
//
// Input channel (in_valid/in_ready/sample_in) takes one signed 16-bit sample per
// transaction; output channel (out_valid/out_ready/sample_out) returns one
// reverberated sample per input transaction, in order.
// Configuration: cfg_write with cfg_index 0 = feedback_gain, 1 = allpass_gain,
// 2 = output_gain (unsigned Q1.15); other indexes are ignored. Write only while idle.
// Each sample runs through an 11-step sequence on one shared multiplier
// (nine products, one register after each), so in_ready is high for one idle
// cycle between samples and a new sample is taken only after the previous one
// has finished its sequence; out_valid rises when the last step completes.
// The result sits in an output register, so a stalled receiver does not block
// the next input; the sequence holds at its last step only when a new result
// is ready while the previous one is still not taken.
// Reset (synchronous, active high) restores the gains and clears all six delay
// lines, one address per cycle in parallel, up to the longest line length
// (1356 at the defaults); in_ready stays low until the clear is done.
`default_nettype none
module comb_allpass_reverb #(
  parameter int COMB_LEN_A    = crb_pkg::COMB_LEN_A_DEF,
  parameter int COMB_LEN_B    = crb_pkg::COMB_LEN_B_DEF,
  parameter int COMB_LEN_C    = crb_pkg::COMB_LEN_C_DEF,
  parameter int COMB_LEN_D    = crb_pkg::COMB_LEN_D_DEF,
  parameter int ALLPASS_LEN_A = crb_pkg::ALLPASS_LEN_A_DEF,
  parameter int ALLPASS_LEN_B = crb_pkg::ALLPASS_LEN_B_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire crb_pkg::sample_t                sample_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output crb_pkg::sample_t                     sample_out,
  input  wire logic                            cfg_write,
  input  wire logic [crb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crb_pkg::GAIN_W-1:0]      cfg_data
);

  localparam int MAX_AB  = (COMB_LEN_A > COMB_LEN_B) ? COMB_LEN_A : COMB_LEN_B;
  localparam int MAX_CD  = (COMB_LEN_C > COMB_LEN_D) ? COMB_LEN_C : COMB_LEN_D;
  localparam int MAX_AP  = (ALLPASS_LEN_A > ALLPASS_LEN_B) ? ALLPASS_LEN_A : ALLPASS_LEN_B;
  localparam int MAX_CB  = (MAX_AB > MAX_CD) ? MAX_AB : MAX_CD;
  localparam int CLR_MAX = (MAX_CB > MAX_AP) ? MAX_CB : MAX_AP;
  localparam int CLR_W   = $clog2(CLR_MAX + 1);

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_COMB_A  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_COMB_B  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_COMB_C  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_COMB_D  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_APA_FB  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_APA_FF  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_APB_FB  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_APB_FF  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_APB_OUT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_GAIN    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST    = 4'd10;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [STEP_W-1:0]     step;
  logic [CLR_W-1:0]      clr_cnt;

  crb_pkg::gain_t        feedback_gain;
  crb_pkg::gain_t        allpass_gain;
  crb_pkg::gain_t        output_gain;

  crb_pkg::sample_t      x;
  crb_pkg::sample_t      y;
  crb_pkg::sample_t      b_ca, b_cb, b_cc, b_cd, b_apa, b_apb;
  crb_pkg::sum_t         dry_sum;
  crb_pkg::sample_t      comb_wd;
  crb_pkg::sample_t      ap_wd;

  crb_pkg::sample_t      mul_sample;
  crb_pkg::gain_t        mul_gain;
  logic                  mul_en;
  crb_pkg::prod_t        prod;

  logic                  running;
  logic                  clearing;
  logic                  fire_last;
  crb_pkg::line_ctl_t    ctl_ca, ctl_cb, ctl_cc, ctl_cd, ctl_apa, ctl_apb;

  assign running   = (state == S_RUN);
  assign clearing  = (state == S_CLEAR);
  assign in_ready  = (state == S_IDLE);
  assign fire_last = running && (step == STEP_LAST) && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= crb_pkg::FEEDBACK_GAIN_RST;
      allpass_gain  <= crb_pkg::ALLPASS_GAIN_RST;
      output_gain   <= crb_pkg::OUTPUT_GAIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        crb_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        crb_pkg::REG_ALLPASS_GAIN:  allpass_gain  <= cfg_data;
        crb_pkg::REG_OUTPUT_GAIN:   output_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == CLR_W'(CLR_MAX - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (fire_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      step    <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (in_valid && in_ready) begin
        step <= STEP_COMB_A;
      end else if (running && step != STEP_LAST) begin
        step <= step + 1'b1;
      end
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_sample = y;
    mul_gain   = allpass_gain;
    mul_en     = running;
    case (step)
      STEP_COMB_A: begin mul_sample = b_ca;  mul_gain = feedback_gain; end
      STEP_COMB_B: begin mul_sample = b_cb;  mul_gain = feedback_gain; end
      STEP_COMB_C: begin mul_sample = b_cc;  mul_gain = feedback_gain; end
      STEP_COMB_D: begin mul_sample = b_cd;  mul_gain = feedback_gain; end
      STEP_APA_FB: mul_sample = b_apa;
      STEP_APA_FF: mul_sample = y;
      STEP_APB_FB: mul_sample = b_apb;
      STEP_APB_FF: mul_sample = y;
      STEP_GAIN:   mul_gain   = output_gain;
      default:     mul_en     = 1'b0;
    endcase
  end

  crb_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .sample (mul_sample),
    .gain   (mul_gain),
    .prod   (prod)
  );

  assign dry_sum = crb_pkg::SUM_W'(x) + crb_pkg::SUM_W'(b_ca) + crb_pkg::SUM_W'(b_cb)
                 + crb_pkg::SUM_W'(b_cc) + crb_pkg::SUM_W'(b_cd);
  assign comb_wd = crb_pkg::sat16(crb_pkg::SUM_W'(x) + crb_pkg::SUM_W'(prod));
  assign ap_wd   = crb_pkg::sat16(crb_pkg::SUM_W'(y) + crb_pkg::SUM_W'(prod));

  // sample and running value
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x <= sample_in;
    end
    if (running) begin
      case (step)
        STEP_COMB_A:  y <= crb_pkg::sat16(dry_sum);
        STEP_APB_FB:  y <= crb_pkg::sat16(crb_pkg::SUM_W'(b_apa) - crb_pkg::SUM_W'(prod));
        STEP_APB_OUT: y <= crb_pkg::sat16(crb_pkg::SUM_W'(b_apb) - crb_pkg::SUM_W'(prod));
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_last) begin
      sample_out <= crb_pkg::sat16(crb_pkg::SUM_W'(prod));
    end
  end

  // delay line control
  assign ctl_ca  = '{clr: clearing, re: in_ready, we: running && step == STEP_COMB_B,
                     adv: fire_last};
  assign ctl_cb  = '{clr: clearing, re: in_ready, we: running && step == STEP_COMB_C,
                     adv: fire_last};
  assign ctl_cc  = '{clr: clearing, re: in_ready, we: running && step == STEP_COMB_D,
                     adv: fire_last};
  assign ctl_cd  = '{clr: clearing, re: in_ready, we: running && step == STEP_APA_FB,
                     adv: fire_last};
  assign ctl_apa = '{clr: clearing, re: in_ready, we: running && step == STEP_APA_FF,
                     adv: fire_last};
  assign ctl_apb = '{clr: clearing, re: in_ready, we: running && step == STEP_APB_FF,
                     adv: fire_last};

  crb_line #(.LEN(COMB_LEN_A), .CLR_W(CLR_W)) u_comb_a (
    .clk(clk), .rst(rst), .ctl(ctl_ca), .clr_addr(clr_cnt), .wdata(comb_wd), .rdata(b_ca)
  );
  crb_line #(.LEN(COMB_LEN_B), .CLR_W(CLR_W)) u_comb_b (
    .clk(clk), .rst(rst), .ctl(ctl_cb), .clr_addr(clr_cnt), .wdata(comb_wd), .rdata(b_cb)
  );
  crb_line #(.LEN(COMB_LEN_C), .CLR_W(CLR_W)) u_comb_c (
    .clk(clk), .rst(rst), .ctl(ctl_cc), .clr_addr(clr_cnt), .wdata(comb_wd), .rdata(b_cc)
  );
  crb_line #(.LEN(COMB_LEN_D), .CLR_W(CLR_W)) u_comb_d (
    .clk(clk), .rst(rst), .ctl(ctl_cd), .clr_addr(clr_cnt), .wdata(comb_wd), .rdata(b_cd)
  );
  crb_line #(.LEN(ALLPASS_LEN_A), .CLR_W(CLR_W)) u_allpass_a (
    .clk(clk), .rst(rst), .ctl(ctl_apa), .clr_addr(clr_cnt), .wdata(ap_wd), .rdata(b_apa)
  );
  crb_line #(.LEN(ALLPASS_LEN_B), .CLR_W(CLR_W)) u_allpass_b (
    .clk(clk), .rst(rst), .ctl(ctl_apb), .clr_addr(clr_cnt), .wdata(ap_wd), .rdata(b_apb)
  );

`ifndef SYNTHESIS
  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RUN && step == STEP_COMB_A))
    else $error("input transaction did not start the sequence");

  a_last_loads_output: assert property (@(posedge clk) disable iff (rst)
    fire_last |=> (out_valid && state == S_IDLE))
    else $error("finished sample not presented on the output");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (rst)
    (running && step == STEP_LAST && out_valid && !out_ready)
      |=> (running && step == STEP_LAST && $stable(prod)))
    else $error("sequence left its last step while output was stalled");
`endif

endmodule
`default_nettype wire

// ----- src/crb_mul.sv -----
// Shared sample-by-gain multiplier with round half up and a result register.
`default_nettype none
module crb_mul (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire crb_pkg::sample_t     sample,
  input  wire crb_pkg::gain_t       gain,
  output crb_pkg::prod_t            prod
);

  logic signed [32:0] full;

  always_comb begin
    full = 33'(sample) * $signed({1'b0, gain}) + 33'sd16384;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[32:15];
    end
  end

endmodule
`default_nettype wire

// ----- src/crb_line.sv -----
// One circular delay line: memory, pointer with wrap, and clearing write path.
`default_nettype none
module crb_line #(
  parameter int LEN   = crb_pkg::COMB_LEN_A_DEF,
  parameter int CLR_W = 11
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire crb_pkg::line_ctl_t  ctl,
  input  wire logic [CLR_W-1:0]    clr_addr,
  input  wire crb_pkg::sample_t    wdata,
  output crb_pkg::sample_t         rdata
);

  localparam int AW = $clog2(LEN);

  crb_pkg::sample_t mem [LEN];
  logic [AW-1:0]    ptr;
  logic [AW-1:0]    ptr_next;
  logic [AW-1:0]    waddr;
  logic             we;
  crb_pkg::sample_t wd;

  always_comb begin
    ptr_next = (ptr == AW'(LEN - 1)) ? '0 : ptr + 1'b1;
    if (ctl.clr) begin
      waddr = clr_addr[AW-1:0];
      we    = (clr_addr < CLR_W'(LEN));
      wd    = '0;
    end else begin
      waddr = ptr;
      we    = ctl.we;
      wd    = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wd;
    end
    if (ctl.re) begin
      rdata <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctl.adv) begin
      ptr <= ptr_next;
    end
  end

endmodule
`default_nettype wire
